/* sv/bnc_pkg.sv */
`timescale 1ns / 1ps
// Package of shared types, codes and constants for the bracket nesting checker.
package bnc_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_line;
    } t_item;

    typedef struct packed {
        logic [1:0]  line_status;
        logic [14:0] illegal_points;
        logic [62:0] completion_score;
        logic        score_saturated;
    } t_result;

    // One classified character as it travels from the front to the back.
    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
        logic       eol;
    } t_cls;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_FILL,
        ST_END,
        ST_WALK,
        ST_EMIT
    } t_state;

    localparam logic [1:0] LS_COMPLETE   = 2'd0;
    localparam logic [1:0] LS_INCOMPLETE = 2'd1;
    localparam logic [1:0] LS_CORRUPTED  = 2'd2;
    localparam logic [1:0] LS_OVERFLOW   = 2'd3;

    localparam logic [7:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E;

    localparam logic [1:0] KIND_PAREN  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;
    localparam logic [1:0] KIND_ANGLE  = 2'd3;

    localparam logic [62:0] SCORE_MAX = {63{1'b1}};

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    function automatic logic [14:0] kind_points(input logic [1:0] kind);
        logic [14:0] pts;
        case (kind)
            KIND_PAREN:  pts = 15'd3;
            KIND_SQUARE: pts = 15'd57;
            KIND_CURLY:  pts = 15'd1197;
            KIND_ANGLE:  pts = 15'd25137;
            default:     pts = 15'd0;
        endcase
        return pts;
    endfunction

endpackage

/* sv/bnc_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module bnc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/bnc_front.sv */
`timescale 1ns / 1ps
// Front end: classifies incoming characters and queues them for the back end.
module bnc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  bnc_pkg::t_item i_item,
    output logic          full,
    output logic          o_q_valid,
    output bnc_pkg::t_cls o_q_item,
    input  logic          i_q_take
);

    import bnc_pkg::*;

    t_cls             cls;
    t_cls             r_q [Q_DEPTH];
    logic [Q_AW-1:0]  r_wp;
    logic [Q_AW-1:0]  r_rp;
    logic [Q_AW:0]    r_cnt;
    logic             enq;
    logic             deq;

    always_comb begin
        cls          = '0;
        cls.eol      = i_item.end_of_line;
        case (i_item.symbol)
            CH_OPEN_PAREN:   begin cls.is_open  = 1'b1; cls.kind = KIND_PAREN;  end
            CH_OPEN_SQUARE:  begin cls.is_open  = 1'b1; cls.kind = KIND_SQUARE; end
            CH_OPEN_CURLY:   begin cls.is_open  = 1'b1; cls.kind = KIND_CURLY;  end
            CH_OPEN_ANGLE:   begin cls.is_open  = 1'b1; cls.kind = KIND_ANGLE;  end
            CH_CLOSE_PAREN:  begin cls.is_close = 1'b1; cls.kind = KIND_PAREN;  end
            CH_CLOSE_SQUARE: begin cls.is_close = 1'b1; cls.kind = KIND_SQUARE; end
            CH_CLOSE_CURLY:  begin cls.is_close = 1'b1; cls.kind = KIND_CURLY;  end
            CH_CLOSE_ANGLE:  begin cls.is_close = 1'b1; cls.kind = KIND_ANGLE;  end
            default:         cls.kind = KIND_PAREN;
        endcase
    end

    assign full      = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign enq       = push && !full;
    assign o_q_valid = (r_cnt != '0);
    assign deq       = i_q_take && o_q_valid;
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (deq) begin
                r_rp <= r_rp + 1'b1;
            end
            if (enq && !deq) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (deq && !enq) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

/* sv/bnc_back.sv */
`timescale 1ns / 1ps
// Back end: bracket stack, line state, completion score walk and result register.
module bnc_back #(
    parameter int STACK_DEPTH = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  bnc_pkg::t_cls    i_q_item,
    output logic             o_q_take,
    output logic             empty,
    input  logic             pop,
    output bnc_pkg::t_result o_result
);

    import bnc_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_state          r_state;
    t_state          n_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    logic            r_corrupt;
    logic            n_corrupt;
    logic [14:0]     r_points;
    logic [14:0]     n_points;
    logic            r_ovf;
    logic            n_ovf;
    logic            r_eol;
    logic            n_eol;
    logic [1:0]      r_top;
    logic [1:0]      n_top;
    logic [AW-1:0]   r_idx;
    logic [AW-1:0]   n_idx;
    logic [62:0]     r_score;
    logic [62:0]     n_score;
    logic            r_sat;
    logic            n_sat;
    logic [1:0]      r_status;
    logic [1:0]      n_status;
    logic            r_out_valid;
    logic            n_out_valid;
    t_result         r_out;
    t_result         n_out;

    logic            take;
    logic            active;
    logic            push_ok;
    logic            pop_hit;
    logic            need_fill;
    logic            slot_free;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [1:0]      ram_rdata;
    logic [2:0]      digit;
    logic [65:0]     s5;
    logic            step_sat;
    logic [62:0]     step_score;

    bnc_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_q_item.kind),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign take      = (r_state == ST_RUN) && i_q_valid;
    assign active    = !r_corrupt && !r_ovf;
    assign push_ok   = r_count != CW'(STACK_DEPTH);
    assign pop_hit   = (r_count != '0) && (r_top == i_q_item.kind);
    assign need_fill = active && i_q_item.is_close && pop_hit && (r_count > CW'(1));
    assign slot_free = !r_out_valid || pop;

    assign digit      = {1'b0, ram_rdata} + 3'd1;
    assign s5         = {1'b0, r_score, 2'b00} + {3'b000, r_score} + {63'd0, digit};
    assign step_sat   = r_sat || (s5[65:63] != 3'b000);
    assign step_score = step_sat ? SCORE_MAX : s5[62:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (take) begin
                    if (need_fill) begin
                        n_state = ST_FILL;
                    end else if (i_q_item.eol) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_FILL: begin
                n_state = r_eol ? ST_END : ST_RUN;
            end
            ST_END: begin
                if (!r_ovf && !r_corrupt && (r_count > CW'(1))) begin
                    n_state = ST_WALK;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_WALK: begin
                if (r_idx == '0) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_comb begin
        o_q_take  = take;
        ram_we    = take && active && i_q_item.is_open && push_ok;
        ram_waddr = r_count[AW-1:0];
        case (r_state)
            ST_WALK: ram_raddr = r_idx - 1'b1;
            default: ram_raddr = AW'(r_count - CW'(2));
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_corrupt   = r_corrupt;
        n_points    = r_points;
        n_ovf       = r_ovf;
        n_eol       = r_eol;
        n_top       = r_top;
        n_idx       = r_idx;
        n_score     = r_score;
        n_sat       = r_sat;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid && !pop;
        case (r_state)
            ST_RUN: begin
                if (take) begin
                    n_eol = i_q_item.eol;
                    if (active && i_q_item.is_open) begin
                        if (push_ok) begin
                            n_count = r_count + 1'b1;
                            n_top   = i_q_item.kind;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else if (active && i_q_item.is_close) begin
                        if (pop_hit) begin
                            n_count = r_count - 1'b1;
                        end else begin
                            n_corrupt = 1'b1;
                            n_points  = kind_points(i_q_item.kind);
                        end
                    end
                end
            end
            ST_FILL: begin
                n_top = ram_rdata;
            end
            ST_END: begin
                n_score = '0;
                n_sat   = 1'b0;
                n_idx   = AW'(r_count - CW'(2));
                if (r_ovf) begin
                    n_status = LS_OVERFLOW;
                end else if (r_corrupt) begin
                    n_status = LS_CORRUPTED;
                end else if (r_count == '0) begin
                    n_status = LS_COMPLETE;
                end else begin
                    n_status = LS_INCOMPLETE;
                    n_score  = {61'd0, r_top} + 63'd1;
                end
            end
            ST_WALK: begin
                n_score = step_score;
                n_sat   = step_sat;
                n_idx   = r_idx - 1'b1;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out.line_status      = r_status;
                    n_out.illegal_points   = (r_status == LS_CORRUPTED) ? r_points : 15'd0;
                    n_out.completion_score = r_score;
                    n_out.score_saturated  = r_sat;
                    n_out_valid            = 1'b1;
                    n_count                = '0;
                    n_corrupt              = 1'b0;
                    n_points               = '0;
                    n_ovf                  = 1'b0;
                    n_eol                  = 1'b0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RUN;
            r_count     <= '0;
            r_corrupt   <= 1'b0;
            r_points    <= '0;
            r_ovf       <= 1'b0;
            r_eol       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_corrupt   <= n_corrupt;
            r_points    <= n_points;
            r_ovf       <= n_ovf;
            r_eol       <= n_eol;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_idx    <= n_idx;
        r_score  <= n_score;
        r_sat    <= n_sat;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

endmodule

/* sv/bracket_nesting_checker_unit.sv */
`timescale 1ns / 1ps
// Top level of the bracket nesting checker: front end, queue and back end.
//
// Each transfer carries one character and an end-of-line flag; one result per
// line comes out after its last character. A front end classifies characters
// into a four-entry queue; push is taken while the back end works, until full.
// The back end handles one character per cycle, except a matching closer that
// leaves the stack non-empty, which also passes through a fill state while the
// new top is read back from the stack RAM. At a line end the back end passes
// through an end state for status and, on an incomplete line, a walk state
// with one step per open bracket beyond the first for the completion score.
// The emit state then waits while an earlier result has not been popped.
// The result register holds one finished line while the next line is scanned.
module bracket_nesting_checker_unit #(
    parameter int STACK_DEPTH = 128
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  bnc_pkg::t_item   i_item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output bnc_pkg::t_result o_result
);

    import bnc_pkg::*;

    logic q_valid;
    t_cls q_item;
    logic q_take;

    bnc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .i_item    (i_item),
        .full      (full),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_take  (q_take)
    );

    bnc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_take  (q_take),
        .empty     (empty),
        .pop       (pop),
        .o_result  (o_result)
    );

`ifndef SYNTHESIS
    a_score_only_incomplete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.line_status != LS_INCOMPLETE)) |->
            ((o_result.completion_score == '0) && !o_result.score_saturated))
        else $error("Score reported on a line that is not incomplete.");

    a_points_only_corrupted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.line_status != LS_CORRUPTED)) |->
            (o_result.illegal_points == '0))
        else $error("Illegal points reported on a line that is not corrupted.");

    a_saturated_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.score_saturated) |-> (o_result.completion_score == SCORE_MAX))
        else $error("Saturated score is not at its maximum.");
`endif

endmodule
